[src/llrc_pkg.sv]
// ----------------------------------------------------------------------------
// llrc_pkg - shared types and constants for the laser line row centroid unit
// Payload words, configuration word, register indexes and divider states.
// ----------------------------------------------------------------------------
package llrc_pkg;

   // Image geometry
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);       // column inside the image
   localparam int CNT_W     = $clog2(2 * MAX_WIDTH);   // saturating column counter
   localparam logic [CNT_W-1:0] COL_MAX   = CNT_W'(2 * MAX_WIDTH - 1);
   localparam logic [CNT_W-1:0] WIDTH_CAP = CNT_W'(MAX_WIDTH);

   // Field widths
   localparam int PIX_W = 8;
   localparam int LEN_W = 6;
   localparam int WIN_W = 12;
   localparam int POS_W = COL_W + PIX_W;               // 11.8 fixed point

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END   = 3'd4;

   localparam logic [PIX_W-1:0] RST_THRESHOLD    = 8'd40;
   localparam logic [LEN_W-1:0] RST_MIN_LENGTH   = 6'd5;
   localparam logic [LEN_W-1:0] RST_MAX_LENGTH   = 6'd30;
   localparam logic [WIN_W-1:0] RST_WINDOW_START = 12'd0;
   localparam logic [WIN_W-1:0] RST_WINDOW_END   = 12'd2048;

   typedef struct packed {
      logic [PIX_W-1:0] intensity;
      logic             last_in_row;
   } llrc_req_type;

   typedef struct packed {
      logic             line_found;
      logic [POS_W-1:0] line_position;
   } llrc_rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] intensity_threshold;
      logic [LEN_W-1:0] min_length;
      logic [LEN_W-1:0] max_length;
      logic [WIN_W-1:0] window_start;
      logic [WIN_W-1:0] window_end;
   } llrc_cfg_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } llrc_div_state_type;

endpackage

[src/llrc_front.sv]
// ----------------------------------------------------------------------------
// llrc_front - pixel scanner
// Counts columns, tracks bright runs inside the window and emits one row
// record (found flag, held sums) on the last pixel of each row.
// ----------------------------------------------------------------------------
module llrc_front #(
   parameter int RUN_COUNT_LIMIT = 63,
   parameter int RUN_W   = $clog2(RUN_COUNT_LIMIT + 1),
   parameter int IW      = llrc_pkg::PIX_W + RUN_W,
   parameter int SW      = llrc_pkg::COL_W + llrc_pkg::PIX_W + RUN_W,
   parameter int ENTRY_W = 1 + SW + IW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pix_accept,
   input  llrc_pkg::llrc_req_type pix,
   input  llrc_pkg::llrc_cfg_type cfg,
   output logic                  push,
   output logic [ENTRY_W-1:0]    push_data
);

   localparam int CMP_W  = (RUN_W > llrc_pkg::LEN_W) ? RUN_W : llrc_pkg::LEN_W;
   localparam int PROD_W = llrc_pkg::COL_W + llrc_pkg::PIX_W;

   logic [llrc_pkg::CNT_W-1:0] col_ff, col_in;
   logic                       in_run_ff, in_run_in;
   logic [SW-1:0]              wsum_ff, wsum_in;
   logic [IW-1:0]              isum_ff, isum_in;
   logic [RUN_W-1:0]           run_ff, run_in;
   logic                       found_ff, found_in;
   logic [SW-1:0]              held_sum_ff, held_sum_in;
   logic [IW-1:0]              held_w_ff, held_w_in;

   logic [llrc_pkg::CNT_W-1:0] wend;
   logic                       in_window;
   logic                       lit;
   logic                       qualifies;
   logic [PROD_W-1:0]          prod;

   assign wend = (cfg.window_end > llrc_pkg::WIDTH_CAP) ? llrc_pkg::WIDTH_CAP : cfg.window_end;
   assign in_window = (col_ff >= cfg.window_start) && (col_ff < wend) && !found_ff;
   assign lit = pix.intensity >= cfg.intensity_threshold;
   assign prod = col_ff[llrc_pkg::COL_W-1:0] * pix.intensity;
   assign qualifies = (CMP_W'(run_ff) > CMP_W'(cfg.min_length)) &&
                      (CMP_W'(run_ff) < CMP_W'(cfg.max_length));

   always_comb begin
      col_in      = col_ff;
      in_run_in   = in_run_ff;
      wsum_in     = wsum_ff;
      isum_in     = isum_ff;
      run_in      = run_ff;
      found_in    = found_ff;
      held_sum_in = held_sum_ff;
      held_w_in   = held_w_ff;
      push        = 1'b0;
      push_data   = '0;

      if (pix_accept) begin
         if (in_window && lit) begin
            in_run_in = 1'b1;
            // count saturates, sums freeze with it
            if (run_ff < RUN_W'(RUN_COUNT_LIMIT)) begin
               wsum_in = wsum_ff + SW'(prod);
               isum_in = isum_ff + IW'(pix.intensity);
               run_in  = run_ff + 1'b1;
            end
         end else begin
            if (in_window && in_run_ff && qualifies) begin
               found_in    = 1'b1;
               held_sum_in = wsum_ff;
               held_w_in   = isum_ff;
            end
            // drop the run: ended, left the window, or nothing open
            in_run_in = 1'b0;
            wsum_in   = '0;
            isum_in   = '0;
            run_in    = '0;
         end

         if (col_ff < llrc_pkg::COL_MAX) begin
            col_in = col_ff + 1'b1;
         end

         if (pix.last_in_row) begin
            push      = 1'b1;
            push_data = {found_in, held_sum_in, held_w_in};
            col_in      = '0;
            in_run_in   = 1'b0;
            wsum_in     = '0;
            isum_in     = '0;
            run_in      = '0;
            found_in    = 1'b0;
            held_sum_in = '0;
            held_w_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         in_run_ff   <= 1'b0;
         wsum_ff     <= '0;
         isum_ff     <= '0;
         run_ff      <= '0;
         found_ff    <= 1'b0;
         held_sum_ff <= '0;
         held_w_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         in_run_ff   <= in_run_in;
         wsum_ff     <= wsum_in;
         isum_ff     <= isum_in;
         run_ff      <= run_in;
         found_ff    <= found_in;
         held_sum_ff <= held_sum_in;
         held_w_ff   <= held_w_in;
      end
   end

endmodule

[src/llrc_queue.sv]
// ----------------------------------------------------------------------------
// llrc_queue - short row record queue
// Register FIFO between the scanner and the divider.
// ----------------------------------------------------------------------------
module llrc_queue #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == NW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

[src/llrc_back.sv]
// ----------------------------------------------------------------------------
// llrc_back - centroid divider and result register
// Restoring divide, one quotient bit a cycle, then holds the result word.
// ----------------------------------------------------------------------------
module llrc_back #(
   parameter int RUN_COUNT_LIMIT = 63,
   parameter int RUN_W   = $clog2(RUN_COUNT_LIMIT + 1),
   parameter int IW      = llrc_pkg::PIX_W + RUN_W,
   parameter int SW      = llrc_pkg::COL_W + llrc_pkg::PIX_W + RUN_W,
   parameter int ENTRY_W = 1 + SW + IW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  logic [ENTRY_W-1:0]     q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output llrc_pkg::llrc_rsp_type rsp_data
);

   localparam int QW = llrc_pkg::POS_W;
   localparam int KW = $clog2(QW);

   llrc_pkg::llrc_div_state_type state_ff, state_in;

   logic [IW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;     // dividend low bits shift out, quotient shifts in
   logic [IW-1:0] div_ff, div_in;
   logic          found_ff, found_in;
   logic [KW-1:0] step_ff, step_in;
   logic          out_valid_ff, out_valid_in;
   llrc_pkg::llrc_rsp_type out_ff, out_in;

   logic          head_found;
   logic [SW-1:0] head_sum;
   logic [IW-1:0] head_w;
   logic [IW:0]   trial;
   logic [IW:0]   diff;
   logic          take;

   assign {head_found, head_sum, head_w} = q_head;
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign take  = trial >= {1'b0, div_ff};

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      found_in     = found_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         llrc_pkg::DIV_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               found_in = head_found;
               div_in   = head_w;
               step_in  = KW'(QW - 1);
               if (head_found && head_w != '0) begin
                  rem_in   = head_sum[SW-1:llrc_pkg::COL_W];
                  quo_in   = {head_sum[llrc_pkg::COL_W-1:0], {llrc_pkg::PIX_W{1'b0}}};
                  state_in = llrc_pkg::DIV_RUN;
               end else begin
                  rem_in   = '0;
                  quo_in   = '0;
                  state_in = llrc_pkg::DIV_DONE;
               end
            end
         end
         llrc_pkg::DIV_RUN: begin
            rem_in = take ? diff[IW-1:0] : trial[IW-1:0];
            quo_in = {quo_ff[QW-2:0], take};
            if (step_ff == '0) begin
               state_in = llrc_pkg::DIV_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         llrc_pkg::DIV_DONE: begin
            // hold until the result register is free
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in         = 1'b1;
               out_in.line_found    = found_ff;
               out_in.line_position = found_ff ? quo_ff : '0;
               state_in             = llrc_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = llrc_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llrc_pkg::DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      found_ff <= found_in;
      step_ff  <= step_in;
      out_ff   <= out_in;
   end

endmodule

[src/laser_line_row_centroid_unit.sv]
// ----------------------------------------------------------------------------
// laser_line_row_centroid_unit - laser line centroid per image row
// Latency: a row's result word passes the row queue, the centroid divider and
//    the result register on its way to rsp; a row with no line skips the divide.
// Throughput: one pixel word per cycle while the 2-entry row queue has room;
//    the shared 19-step centroid divider takes one row record at a time.
// Reset: synchronous; restores the registers (40, 5, 30, 0, 2048), clears row
//    state and the queue; no clearing pass, ready again the next cycle.
// ----------------------------------------------------------------------------
module laser_line_row_centroid_unit #(
   parameter int RUN_COUNT_LIMIT = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  llrc_pkg::llrc_req_type              req_data,
   // row result words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output llrc_pkg::llrc_rsp_type              rsp_data,
   // register writes
   input  logic                                csr_we,
   input  logic [llrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [llrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RUN_W   = $clog2(RUN_COUNT_LIMIT + 1);
   localparam int IW      = llrc_pkg::PIX_W + RUN_W;
   localparam int SW      = llrc_pkg::COL_W + llrc_pkg::PIX_W + RUN_W;
   localparam int ENTRY_W = 1 + SW + IW;
   localparam int Q_DEPTH = 2;

   llrc_pkg::llrc_cfg_type cfg_ff, cfg_in;

   logic               pix_accept;
   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_head;
   logic               q_full;
   logic               q_empty;

   // Take a pixel whenever the row queue has room; only a row end pushes.
   assign req_ready  = !q_full;
   assign pix_accept = req_valid && req_ready;

   // Register file: writes to unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            llrc_pkg::CSR_THRESHOLD:
               cfg_in.intensity_threshold = csr_wdata[llrc_pkg::PIX_W-1:0];
            llrc_pkg::CSR_MIN_LENGTH:
               cfg_in.min_length = csr_wdata[llrc_pkg::LEN_W-1:0];
            llrc_pkg::CSR_MAX_LENGTH:
               cfg_in.max_length = csr_wdata[llrc_pkg::LEN_W-1:0];
            llrc_pkg::CSR_WINDOW_START:
               cfg_in.window_start = csr_wdata[llrc_pkg::WIN_W-1:0];
            llrc_pkg::CSR_WINDOW_END:
               cfg_in.window_end = csr_wdata[llrc_pkg::WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.intensity_threshold <= llrc_pkg::RST_THRESHOLD;
         cfg_ff.min_length          <= llrc_pkg::RST_MIN_LENGTH;
         cfg_ff.max_length          <= llrc_pkg::RST_MAX_LENGTH;
         cfg_ff.window_start        <= llrc_pkg::RST_WINDOW_START;
         cfg_ff.window_end          <= llrc_pkg::RST_WINDOW_END;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: scan pixels, build one record per row.
   llrc_front #(
      .RUN_COUNT_LIMIT (RUN_COUNT_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .pix_accept (pix_accept),
      .pix        (req_data),
      .cfg        (cfg_ff),
      .push       (push),
      .push_data  (push_data)
   );

   // Queue: decouple the scanner from the divider.
   llrc_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: divide held sums and drive the result word.
   llrc_back #(
      .RUN_COUNT_LIMIT (RUN_COUNT_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[src/llrc_checker.sv]
// ----------------------------------------------------------------------------
// llrc_checker - port level checks for the row centroid unit
// Watches the pixel and result channels and tracks rows in flight.
// ----------------------------------------------------------------------------
module llrc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input llrc_pkg::llrc_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input llrc_pkg::llrc_rsp_type rsp_data
);

   logic [3:0] pending_ff, pending_in;
   logic       row_in, row_out;

   assign row_in  = req_valid && req_ready && req_data.last_in_row;
   assign row_out = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (row_in && !row_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (row_out && !row_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // no line, no position
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.line_found |-> rsp_data.line_position == '0)
      else $error("position set without a line");

   // every result belongs to a finished row
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result word without a finished row");

   // reset leaves the unit empty and open for pixels
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("unit not empty after reset");

endmodule

bind laser_line_row_centroid_unit llrc_checker u_llrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - regression for laser_line_row_centroid_unit
// Streams grey pixel words row by row through the valid/ready input while the
// result side stalls at random. A local row scanner tracks the column, the
// lit run and the held centroid, and predicts one row word per last pixel.
// Each row word is checked field by field against the oldest prediction.
// Registers are reprogrammed between phases once every row word is back.
// ----------------------------------------------------------------------------
module testbench;
   import llrc_pkg::*;

   localparam int RUN_LIMIT    = 63;   // run length saturates here
   localparam int DRAIN_CYCLES = 40;   // idle clocks after the last row word is back
   localparam int PHASE_COUNT  = 9;
   localparam int PHASE_ITEMS  = 40;
   // first register index that maps to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_WINDOW_END + 3'd1;

   // one row of the directed table; the row word is typed in where typed is set
   typedef struct packed {
      logic [PIX_W-1:0] intensity;
      logic             last_in_row;
      logic             typed;
      logic             line_found;
      logic [POS_W-1:0] line_position;
   } pixel_step_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   llrc_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   llrc_rsp_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // scanner copy of the registers
   logic [PIX_W-1:0] thr_reg;
   logic [LEN_W-1:0] min_len_reg;
   logic [LEN_W-1:0] max_len_reg;
   logic [WIN_W-1:0] win_start_reg;
   logic [WIN_W-1:0] win_end_reg;

   // scanner row state
   logic [CNT_W-1:0] col_count;
   logic             run_open;
   logic [63:0]      run_wsum;
   logic [63:0]      run_isum;
   logic [LEN_W-1:0] run_len;
   logic             row_locked;
   logic [63:0]      lock_wsum;
   logic [63:0]      lock_isum;

   llrc_rsp_type pending_rows[$];   // row words predicted and not yet seen
   int           fault_count   = 0;
   int           items_sent    = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;

   // Directed rows at reset settings (threshold 40, run 6..29, full window).
   // A lone lit pixel closing the row is an open run: discarded.
   // Six full-scale pixels on columns 1..6 closed by 39 center on 3.5 (896);
   // the at-threshold pixel after the lock is ignored.
   // Five lit pixels are one short of the minimum length.
   // The last group closes its run on the row's last pixel.
   pixel_step_type directed_steps[0:24] = '{
      '{8'd255, 1'b1, 1'b1, 1'b0, 19'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd39,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd40,  1'b1, 1'b1, 1'b1, 19'd896},
      '{8'd40,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd40,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd40,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd40,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd40,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd0,   1'b1, 1'b1, 1'b0, 19'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd100, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd200, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd50,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd77,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd255, 1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd90,  1'b0, 1'b0, 1'b0, 19'd0},
      '{8'd1,   1'b1, 1'b0, 1'b0, 19'd0}
   };

   // Corner settings: reset values, widest lengths with the window past the
   // image, threshold zero, empty window, single-pixel runs in a narrow window.
   llrc_cfg_type corner_settings[0:4] = '{
      '{8'd40,  6'd5,  6'd30, 12'd0,    12'd2048},
      '{8'd255, 6'd0,  6'd63, 12'd0,    12'd4095},
      '{8'd0,   6'd0,  6'd63, 12'd0,    12'd2048},
      '{8'd1,   6'd63, 6'd63, 12'd4095, 12'd0},
      '{8'd128, 6'd0,  6'd2,  12'd0,    12'd12}
   };

   laser_line_row_centroid_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Drop the current run and its sums.
   function automatic void close_run();
      run_open = 1'b0;
      run_wsum = '0;
      run_isum = '0;
      run_len  = '0;
   endfunction

   // Scan one pixel word; on the row's last pixel form the row word and
   // clear the row state.
   function automatic void scan_pixel(input llrc_req_type word, output bit has_row,
                                      output llrc_rsp_type row_word);
      logic [WIN_W-1:0] win_hi;
      logic [63:0]      centroid;
      bit               scanned;
      win_hi   = (win_end_reg > WIDTH_CAP) ? WIDTH_CAP : win_end_reg;
      scanned  = (col_count >= win_start_reg) && (col_count < win_hi) && !row_locked;
      centroid = '0;
      if (scanned) begin
         if (word.intensity >= thr_reg) begin
            run_open = 1'b1;
            // past saturation the sums freeze while the run goes on
            if (run_len < RUN_LIMIT) begin
               run_wsum += 64'(col_count) * 64'(word.intensity);
               run_isum += 64'(word.intensity);
               run_len++;
            end
         end else if (run_open) begin
            if (run_len > min_len_reg && run_len < max_len_reg) begin
               row_locked = 1'b1;
               lock_wsum  = run_wsum;
               lock_isum  = run_isum;
            end
            close_run();
         end
      end else begin
         close_run();
      end
      if (col_count < COL_MAX) col_count++;
      has_row  = word.last_in_row;
      row_word = '0;
      if (word.last_in_row) begin
         if (row_locked && lock_isum != 0) centroid = (lock_wsum << 8) / lock_isum;
         row_word.line_found    = row_locked;
         row_word.line_position = row_locked ? centroid[POS_W-1:0] : '0;
         col_count  = '0;
         close_run();
         row_locked = 1'b0;
         lock_wsum  = '0;
         lock_isum  = '0;
      end
   endfunction

   // Pick a lit or a dark pixel for the current threshold, leaning on the
   // threshold boundary now and then.
   function automatic logic [PIX_W-1:0] pick_pixel(input bit lit);
      if (lit) begin
         if ($urandom_range(0, 7) == 0) return thr_reg;
         return PIX_W'($urandom_range(255, thr_reg));
      end
      // with threshold zero nothing is dark; any value is lit
      if (thr_reg == 0) return PIX_W'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) return thr_reg - 8'd1;
      return PIX_W'($urandom_range(thr_reg - 1, 0));
   endfunction

   // Offer one pixel word, hold it until accepted, then predict.
   task automatic send_pixel(input llrc_req_type word, input bit typed,
                             input llrc_rsp_type typed_word);
      bit           has_row;
      llrc_rsp_type row_word;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scan_pixel(word, has_row, row_word);
      if (has_row) pending_rows.push_back(typed ? typed_word : row_word);
      items_sent++;
   endtask

   // Random row: dark background with lit bursts of random length, some of
   // them past saturation; one row in ten is pure noise.
   task automatic send_row(input int len);
      int           burst_left;
      bit           noise;
      llrc_req_type word;
      noise      = ($urandom_range(0, 9) == 0);
      burst_left = 0;
      for (int col = 0; col < len; col++) begin
         if (burst_left == 0 && $urandom_range(0, 5) == 0)
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(36, 75)
                                                       : $urandom_range(1, 35);
         word.intensity   = noise ? PIX_W'($urandom) : pick_pixel(burst_left > 0);
         word.last_in_row = (col == len - 1);
         if (burst_left > 0) burst_left--;
         send_pixel(word, 1'b0, '0);
      end
   endtask

   // Long row with a single lit burst on a dark background.
   task automatic send_long_row(input int len, input int burst_at, input int burst_len);
      llrc_req_type word;
      for (int col = 0; col < len; col++) begin
         word.intensity   = pick_pixel(col >= burst_at && col < burst_at + burst_len);
         word.last_in_row = (col == len - 1);
         send_pixel(word, 1'b0, '0);
      end
   endtask

   // Hold the input idle until every row word is back, then let the
   // pipeline settle.
   task automatic drain_rows();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_we after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_THRESHOLD:    thr_reg       = data[PIX_W-1:0];
         CSR_MIN_LENGTH:   min_len_reg   = data[LEN_W-1:0];
         CSR_MAX_LENGTH:   max_len_reg   = data[LEN_W-1:0];
         CSR_WINDOW_START: win_start_reg = data[WIN_W-1:0];
         CSR_WINDOW_END:   win_end_reg   = data[WIN_W-1:0];
         default: ;
      endcase
   endtask

   // Write all five registers with junk above the narrow fields, then a
   // write to an unused index that must change nothing.
   task automatic program_regs(input llrc_cfg_type cfg);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_THRESHOLD,    {junk[CSR_DATA_W-1:PIX_W], cfg.intensity_threshold});
      write_reg(CSR_MIN_LENGTH,   {junk[CSR_DATA_W-1:LEN_W], cfg.min_length});
      write_reg(CSR_MAX_LENGTH,   {junk[CSR_DATA_W-1:LEN_W], cfg.max_length});
      write_reg(CSR_WINDOW_START, cfg.window_start);
      write_reg(CSR_WINDOW_END,   cfg.window_end);
      write_reg(CSR_SPARE + CSR_IDX_W'($urandom_range(0, 2)), junk);
      csr_we <= 1'b0;
   endtask

   // Result side: check the accepted row word, then pick the next ready.
   always @(posedge clock) begin : row_word_check
      llrc_rsp_type expected_row;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            fault_count++;
            $display("%0t: row word with none pending: found %0b position %0d",
                     $time, rsp_data.line_found, rsp_data.line_position);
         end else begin
            expected_row = pending_rows.pop_front();
            if (rsp_data.line_found !== expected_row.line_found) begin
               fault_count++;
               $display("%0t: line_found expected %0b actual %0b", $time,
                        expected_row.line_found, rsp_data.line_found);
            end
            if (rsp_data.line_position !== expected_row.line_position) begin
               fault_count++;
               $display("%0t: line_position expected %0d actual %0d", $time,
                        expected_row.line_position, rsp_data.line_position);
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin : stimulus
      llrc_cfg_type   cfg;
      pixel_step_type step;
      llrc_req_type   word;
      llrc_rsp_type   typed_word;
      int             first_item;
      int             row_len;
      // scanner starts from the reset state
      thr_reg       = RST_THRESHOLD;
      min_len_reg   = RST_MIN_LENGTH;
      max_len_reg   = RST_MAX_LENGTH;
      win_start_reg = RST_WINDOW_START;
      win_end_reg   = RST_WINDOW_END;
      col_count     = '0;
      close_run();
      row_locked    = 1'b0;
      lock_wsum     = '0;
      lock_isum     = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset register values
      send_idle_pct = 24;
      rsp_stall_pct = 47;
      foreach (directed_steps[i]) begin
         step                     = directed_steps[i];
         word.intensity           = step.intensity;
         word.last_in_row         = step.last_in_row;
         typed_word.line_found    = step.line_found;
         typed_word.line_position = step.line_position;
         send_pixel(word, step.typed, typed_word);
      end
      drain_rows();

      // random phases: corner settings first, then random ones
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 24;
            rsp_stall_pct = 47;
         end else if (phase < 6) begin
            send_idle_pct = 47;
            rsp_stall_pct = 24;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         if (phase < 5) begin
            cfg = corner_settings[phase];
         end else begin
            cfg.intensity_threshold = PIX_W'($urandom_range(1, 250));
            cfg.min_length          = LEN_W'($urandom_range(0, 10));
            cfg.max_length          = LEN_W'($urandom_range(12, 63));
            cfg.window_start        = WIN_W'($urandom_range(0, 20));
            cfg.window_end = ($urandom_range(0, 3) == 0)
                             ? WIN_W'($urandom_range(2049, 4095))
                             : cfg.window_start + WIN_W'($urandom_range(10, 120));
         end
         program_regs(cfg);
         first_item = items_sent;
         // mostly short rows, now and then the rest of the phase in one row
         while (items_sent - first_item < PHASE_ITEMS) begin
            row_len = PHASE_ITEMS - (items_sent - first_item);
            if ($urandom_range(0, 6) != 0 && row_len > 24)
               row_len = $urandom_range(1, 24);
            send_row(row_len);
         end
         drain_rows();
      end

      // Long row: a burst longer than the count limit saturates the run
      // length and freezes the sums while the run goes on.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      program_regs('{8'd60, 6'd2, 6'd40, 12'd0, 12'd4095});
      send_long_row(120, 20, 70);
      drain_rows();

      if (fault_count == 0)
         $display("laser_line_row_centroid_unit regression: pass");
      else
         $display("laser_line_row_centroid_unit regression: fail");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20_000_000;
      $display("laser_line_row_centroid_unit regression: fail");
      $finish;
   end

endmodule
